// ----- src/sfr_pkg.sv -----
package sfr_pkg;

  // result kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  // error codes
  localparam logic [1:0] ERR_FORMAT = 2'd0;
  localparam logic [1:0] ERR_CMD    = 2'd1;
  localparam logic [1:0] ERR_SUM    = 2'd2;

  // input functions
  localparam logic FUNC_BYTE  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // frame markers and limits
  localparam logic [7:0]  HDR0      = 8'hC1;
  localparam logic [7:0]  HDR1      = 8'hD2;
  localparam logic [7:0]  TRL0      = 8'hE3;
  localparam logic [7:0]  TRL1      = 8'hF4;
  localparam logic [7:0]  CMD_MIN   = 8'h01;
  localparam logic [7:0]  CMD_MAX   = 8'h06;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd599;

  // fixed positions of the header bytes and the first payload byte
  localparam logic [16:0] POS_HDR0  = 17'd0;
  localparam logic [16:0] POS_HDR1  = 17'd1;
  localparam logic [16:0] POS_CMD   = 17'd2;
  localparam logic [16:0] POS_LENHI = 17'd3;
  localparam logic [16:0] POS_LENLO = 17'd4;
  localparam logic [16:0] POS_DATA0 = 17'd5;

  // one input word
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } item_t;

  // one result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [2:0]  frame_command;
    logic [15:0] frame_length;
    logic [1:0]  error_code;
    logic        frame_ready;
  } result_t;

endpackage

// ----- src/sfr_in_reg.sv -----
module sfr_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sfr_pkg::item_t      in_item,
  input  logic                advance,
  output logic                item_valid,
  output sfr_pkg::item_t      item
);

  logic accept;

  // hold off upstream while a word waits and cannot move on
  assign in_stall = item_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

endmodule

// ----- src/sfr_parse_core.sv -----
module sfr_parse_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [15:0]         cfg_data,
  input  logic                advance,
  input  sfr_pkg::item_t      item,
  output sfr_pkg::result_t    result
);

  logic [15:0] max_length;
  logic [16:0] position, position_next;
  logic [23:0] running_sum, running_sum_next;
  logic [2:0]  cmd_reg, cmd_reg_next;
  logic [15:0] len_reg, len_reg_next;
  logic [7:0]  sum_high_byte, sum_high_byte_next;
  logic        done_flag, done_flag_next;

  logic [16:0] len_ext;
  logic [16:0] last_data_pos;
  logic [16:0] data_offset;
  logic [15:0] len_full;
  logic [23:0] rx_sum;
  logic        err;
  logic [1:0]  ecode;
  logic [1:0]  kind;
  logic [7:0]  b;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= sfr_pkg::MAX_LENGTH_RESET;
    end else if (cfg_valid) begin
      max_length <= cfg_data;
    end
  end

  assign b             = item.rx_byte;
  assign len_ext       = {1'b0, len_reg};
  assign last_data_pos = len_ext + 17'd4;
  assign data_offset   = position - sfr_pkg::POS_DATA0;
  assign len_full      = {len_reg[7:0], b};
  assign rx_sum        = {8'd0, sum_high_byte, b};

  // parse one word
  always_comb begin
    position_next      = position;
    running_sum_next   = running_sum;
    cmd_reg_next       = cmd_reg;
    len_reg_next       = len_reg;
    sum_high_byte_next = sum_high_byte;
    done_flag_next     = done_flag;
    err                = 1'b0;
    ecode              = sfr_pkg::ERR_FORMAT;
    kind               = sfr_pkg::KIND_NONE;
    result             = '0;

    if (item.func == sfr_pkg::FUNC_CLEAR) begin
      position_next      = '0;
      running_sum_next   = '0;
      cmd_reg_next       = '0;
      len_reg_next       = '0;
      sum_high_byte_next = '0;
      done_flag_next     = 1'b0;
    end else if (!done_flag) begin
      if (position <= last_data_pos) begin
        running_sum_next = running_sum + {16'd0, b};
      end
      if (position == sfr_pkg::POS_HDR0) begin
        err = (b != sfr_pkg::HDR0);
      end else if (position == sfr_pkg::POS_HDR1) begin
        err = (b != sfr_pkg::HDR1);
      end else if (position == sfr_pkg::POS_CMD) begin
        if (b < sfr_pkg::CMD_MIN || b > sfr_pkg::CMD_MAX) begin
          err   = 1'b1;
          ecode = sfr_pkg::ERR_CMD;
        end else begin
          cmd_reg_next = b[2:0];
        end
      end else if (position == sfr_pkg::POS_LENHI) begin
        len_reg_next = {8'd0, b};
      end else if (position == sfr_pkg::POS_LENLO) begin
        len_reg_next = len_full;
        err          = (len_full > max_length);
      end else if (position <= last_data_pos) begin
        kind                 = sfr_pkg::KIND_DATA;
        result.payload_byte  = b;
        result.payload_index = data_offset[15:0];
      end else if (position == len_ext + 17'd5) begin
        sum_high_byte_next = b;
      end else if (position == len_ext + 17'd6) begin
        if (rx_sum != running_sum) begin
          err   = 1'b1;
          ecode = sfr_pkg::ERR_SUM;
        end
      end else if (position == len_ext + 17'd7) begin
        err = (b != sfr_pkg::TRL0);
      end else begin
        if (b != sfr_pkg::TRL1) begin
          err = 1'b1;
        end else begin
          done_flag_next = 1'b1;
          kind           = sfr_pkg::KIND_DONE;
        end
      end
      position_next = position + 17'd1;
    end

    // command and length show the values found before any restart
    result.frame_command = cmd_reg_next;
    result.frame_length  = len_reg_next;

    // error restarts the parse
    if (err) begin
      kind              = sfr_pkg::KIND_ERR;
      result.error_code = ecode;
      position_next      = '0;
      running_sum_next   = '0;
      cmd_reg_next       = '0;
      len_reg_next       = '0;
      sum_high_byte_next = '0;
      done_flag_next     = 1'b0;
    end

    result.kind        = kind;
    result.frame_ready = done_flag_next;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      running_sum   <= '0;
      cmd_reg       <= '0;
      len_reg       <= '0;
      sum_high_byte <= '0;
      done_flag     <= 1'b0;
    end else if (advance) begin
      position      <= position_next;
      running_sum   <= running_sum_next;
      cmd_reg       <= cmd_reg_next;
      len_reg       <= len_reg_next;
      sum_high_byte <= sum_high_byte_next;
      done_flag     <= done_flag_next;
    end
  end

endmodule

// ----- src/sfr_out_reg.sv -----
module sfr_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                advance,
  input  sfr_pkg::result_t    result_in,
  output logic                out_valid,
  input  logic                out_stall,
  output sfr_pkg::result_t    result_out
);

  // the result register loads a waiting word whenever it is empty or being taken
  assign advance = up_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_out <= result_in;
    end
  end

endmodule

// ----- src/serial_frame_receiver.sv -----
// Serial frame receiver: takes one word per cycle unless stalled, either a
// received byte or a clear, and returns exactly one result word per input
// word. Frames are C1 D2, command 1..6, 16-bit big-endian length (at most
// max_length), the payload, a 16-bit big-endian checksum of all bytes from
// header through payload, then E3 F4. Payload bytes come out one per result
// with their offset; errors restart the parse; after a good frame bytes are
// ignored until a clear. Each word passes through the input register and then
// the result register, and a new word is taken every cycle while the result
// register is being drained; the rate is set by the compare and add of the
// parser state. max_length is written through the cfg port, which is always
// ready.
module serial_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_index,
  output logic [2:0]  frame_command,
  output logic [15:0] frame_length,
  output logic [1:0]  error_code,
  output logic        frame_ready
);

  sfr_pkg::item_t       in_item;
  sfr_pkg::item_t       item;
  sfr_pkg::result_t     result;
  sfr_pkg::result_t     result_q;
  logic                 item_valid;
  logic                 advance;

  assign cfg_ready = 1'b1;
  assign in_item   = '{func: func, rx_byte: rx_byte};

  sfr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  sfr_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .item      (item),
    .result    (result)
  );

  sfr_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (item_valid),
    .advance    (advance),
    .result_in  (result),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_out (result_q)
  );

  // result word onto its ports
  assign kind          = result_q.kind;
  assign payload_byte  = result_q.payload_byte;
  assign payload_index = result_q.payload_index;
  assign frame_command = result_q.frame_command;
  assign frame_length  = result_q.frame_length;
  assign error_code    = result_q.error_code;
  assign frame_ready   = result_q.frame_ready;

endmodule
